FILE: rtl/core/baro_sensor_compensation_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the barometric compensation block
// Each macro expands to a concurrent assertion in simulation and to nothing
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BARO_SENSOR_COMPENSATION_TOP_MACROS_SVH
`define BARO_SENSOR_COMPENSATION_TOP_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define BSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bsc: same-cycle check failed");

// next-cycle implication
`define BSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bsc: next-cycle check failed");

`else

`define BSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsc_pkg;

    // pipeline depth (register stages from input to output)
    localparam int NUM_STAGES = 9;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_C1     = 3'd0,
        CFG_C2     = 3'd1,
        CFG_C3     = 3'd2,
        CFG_C4     = 3'd3,
        CFG_C5     = 3'd4,
        CFG_C6     = 3'd5,
        CFG_SO_EN  = 3'd6
    } t_cfg_idx;

    // temperature thresholds, hundredths of a degree
    localparam logic signed [18:0] TEMP_REF = 19'sd2000;
    localparam logic signed [18:0] TEMP_LOW = -19'sd1500;

    // pressure window for the valid flag, pascals
    localparam logic signed [31:0] P_MIN = 32'sd80000;
    localparam logic signed [31:0] P_MAX = 32'sd107000;

    // rounding biases for truncating signed shifts
    localparam logic signed [41:0] BIAS_T  = 42'sd8388607;   // 2^23 - 1
    localparam logic signed [41:0] BIAS_O  = 42'sd127;       // 2^7 - 1
    localparam logic signed [41:0] BIAS_S  = 42'sd255;       // 2^8 - 1
    localparam logic signed [63:0] BIAS_P1 = 64'sd2097151;   // 2^21 - 1
    localparam logic signed [43:0] BIAS_P2 = 44'sd32767;     // 2^15 - 1

    // stage enables of the split pressure multiplier
    typedef struct packed {
        logic st_a;   // partial products
        logic st_b;   // recombination
    } t_mul_en;

endpackage

FILE: rtl/core/bsc_pmul.sv
// ----------------------------------------------------------------------------
// bsc_pmul
// Two-stage 24u x 39s multiplier: 24-bit by 20-bit and 24-bit by 19-bit
// partial products, then one 64-bit recombination add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_pmul (
    input  logic                 i_clk,
    input  bsc_pkg::t_mul_en     i_en,
    input  logic [23:0]          i_d1,
    input  logic signed [38:0]   i_sens,
    output logic signed [63:0]   o_prod
);

    logic [43:0]        r_pp_lo;
    logic signed [43:0] r_pp_hi;
    logic signed [63:0] r_prod;

    logic [43:0]        n_pp_lo;
    logic signed [43:0] n_pp_hi;
    logic signed [63:0] n_prod;

    // partial products: low 20 bits unsigned, high 19 bits signed
    always_comb begin
        n_pp_lo = i_d1 * i_sens[19:0];
        n_pp_hi = $signed({1'b0, i_d1}) * $signed(i_sens[38:20]);
    end

    // recombine: hi * 2^20 + lo
    always_comb begin
        n_prod = $signed({r_pp_hi, 20'b0}) + $signed({20'b0, r_pp_lo});
    end

    always_ff @(posedge i_clk) begin
        if (i_en.st_a) begin
            r_pp_lo <= n_pp_lo;
            r_pp_hi <= n_pp_hi;
        end
        if (i_en.st_b) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/core/baro_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation_top
// Second-order temperature and pressure compensation of raw barometer
// conversions, as a nine-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) transfers one pair of raw
//   conversions, D1 pressure and D2 temperature. Output channel
//   (o_out_valid / i_out_ready) transfers the temperature in hundredths of
//   a degree, the pressure in pascals and the in-window flag.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
//   calibration words C1..C6 at index 0..5 and the second-order enable at
//   index 6; other indexes are ignored. Write only while the pipe is empty.
//   One register stage per step (dT, products, first order terms, squares,
//   corrections, partial products, recombination, first divide, final
//   divide). Throughput: one item per cycle while the receiver is ready,
//   set by the fully pipelined datapath.
//   Reset clears all valid bits and restores calibration words to 0 and
//   the second-order enable to 1.
//   When the receiver stalls, each stage holds its item and empty stages
//   ahead keep filling, so the input stays ready until the pipe is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "baro_sensor_compensation_top_macros.svh"

module baro_sensor_compensation_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [23:0]                      i_d1_raw,
    input  logic [23:0]                      i_d2_raw,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [18:0]               o_temperature_centi,
    output logic signed [31:0]               o_pressure_pa,
    output logic                             o_pressure_valid
);

    localparam int NS = bsc_pkg::NUM_STAGES;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_cal_c1, r_cal_c2, r_cal_c3, r_cal_c4, r_cal_c5, r_cal_c6;
    logic        r_so_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_c1 <= '0;
            r_cal_c2 <= '0;
            r_cal_c3 <= '0;
            r_cal_c4 <= '0;
            r_cal_c5 <= '0;
            r_cal_c6 <= '0;
            r_so_en  <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (bsc_pkg::t_cfg_idx'(i_cfg_index))
                bsc_pkg::CFG_C1:    r_cal_c1 <= i_cfg_data;
                bsc_pkg::CFG_C2:    r_cal_c2 <= i_cfg_data;
                bsc_pkg::CFG_C3:    r_cal_c3 <= i_cfg_data;
                bsc_pkg::CFG_C4:    r_cal_c4 <= i_cfg_data;
                bsc_pkg::CFG_C5:    r_cal_c5 <= i_cfg_data;
                bsc_pkg::CFG_C6:    r_cal_c6 <= i_cfg_data;
                bsc_pkg::CFG_SO_EN: r_so_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: a stage loads when empty or when the next loads
    // ------------------------------------------------------------------
    logic [NS:1] r_vld;
    logic [NS:1] w_en;
    logic [NS:1] w_nxt;
    logic [NS:1] w_hold;

    always_comb begin
        w_en[NS] = !r_vld[NS] || i_out_ready;
        for (int k = NS - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign w_nxt  = {i_out_ready, w_en[NS:2]};
    assign w_hold = r_vld & ~w_nxt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = w_en[1];
    assign o_out_valid = r_vld[NS];

    // ------------------------------------------------------------------
    // stage 1: dT = D2 - C5 * 256
    // ------------------------------------------------------------------
    logic [23:0]        r_s1_d1;
    logic signed [24:0] r_s1_dt;
    logic signed [24:0] n_s1_dt;

    assign n_s1_dt = $signed({1'b0, i_d2_raw}) - $signed({1'b0, r_cal_c5, 8'b0});

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1_d1 <= i_d1_raw;
            r_s1_dt <= n_s1_dt;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: products of dT with C6, C4, C3 and itself
    // ------------------------------------------------------------------
    logic [23:0]        r_s2_d1;
    logic signed [41:0] r_s2_pt, r_s2_po, r_s2_ps;
    logic [47:0]        r_s2_pd;
    logic signed [41:0] n_s2_pt, n_s2_po, n_s2_ps;
    logic signed [49:0] n_s2_pd;

    always_comb begin
        n_s2_pt = r_s1_dt * $signed({1'b0, r_cal_c6});
        n_s2_po = r_s1_dt * $signed({1'b0, r_cal_c4});
        n_s2_ps = r_s1_dt * $signed({1'b0, r_cal_c3});
        n_s2_pd = r_s1_dt * r_s1_dt;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s2_d1 <= r_s1_d1;
            r_s2_pt <= n_s2_pt;
            r_s2_po <= n_s2_po;
            r_s2_ps <= n_s2_ps;
            r_s2_pd <= n_s2_pd[47:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 3: TEMP, OFF, SENS, TEMP2 (truncating shifts)
    // ------------------------------------------------------------------
    logic [23:0]        r_s3_d1;
    logic signed [18:0] r_s3_temp;
    logic signed [36:0] r_s3_off;
    logic signed [35:0] r_s3_sens;
    logic [16:0]        r_s3_temp2;

    logic signed [41:0] w_s3_bt, w_s3_bo, w_s3_bs;
    logic signed [18:0] n_s3_temp;
    logic signed [36:0] n_s3_off;
    logic signed [35:0] n_s3_sens;

    always_comb begin
        w_s3_bt   = r_s2_pt + (r_s2_pt[41] ? bsc_pkg::BIAS_T : 42'sd0);
        w_s3_bo   = r_s2_po + (r_s2_po[41] ? bsc_pkg::BIAS_O : 42'sd0);
        w_s3_bs   = r_s2_ps + (r_s2_ps[41] ? bsc_pkg::BIAS_S : 42'sd0);
        n_s3_temp = bsc_pkg::TEMP_REF + $signed(w_s3_bt[41:23]);
        n_s3_off  = $signed({5'b0, r_cal_c2, 16'b0})
                  + 37'($signed(w_s3_bo[41:7]));
        n_s3_sens = $signed({5'b0, r_cal_c1, 15'b0})
                  + 36'($signed(w_s3_bs[41:8]));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s3_d1    <= r_s2_d1;
            r_s3_temp  <= n_s3_temp;
            r_s3_off   <= n_s3_off;
            r_s3_sens  <= n_s3_sens;
            r_s3_temp2 <= r_s2_pd[47:31];
        end
    end

    // ------------------------------------------------------------------
    // stage 4: low temperature tests, squares, final temperature
    // ------------------------------------------------------------------
    logic [23:0]        r_s4_d1;
    logic signed [36:0] r_s4_off;
    logic signed [35:0] r_s4_sens;
    logic [33:0]        r_s4_sq, r_s4_sq2;
    logic signed [18:0] r_s4_tout;
    logic               r_s4_lo1, r_s4_lo2;

    logic               n_s4_lo1, n_s4_lo2;
    logic signed [19:0] w_s4_a, w_s4_b;
    logic signed [39:0] w_s4_sqa, w_s4_sqb;
    logic signed [19:0] w_s4_tout;

    always_comb begin
        n_s4_lo1  = r_so_en && (r_s3_temp < bsc_pkg::TEMP_REF);
        n_s4_lo2  = n_s4_lo1 && (r_s3_temp < bsc_pkg::TEMP_LOW);
        w_s4_a    = 20'(r_s3_temp) - 20'(bsc_pkg::TEMP_REF);
        w_s4_b    = 20'(r_s3_temp) - 20'(bsc_pkg::TEMP_LOW);
        w_s4_sqa  = w_s4_a * w_s4_a;
        w_s4_sqb  = w_s4_b * w_s4_b;
        w_s4_tout = 20'(r_s3_temp)
                  - (n_s4_lo1 ? $signed({3'b0, r_s3_temp2}) : 20'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s4_d1   <= r_s3_d1;
            r_s4_off  <= r_s3_off;
            r_s4_sens <= r_s3_sens;
            r_s4_sq   <= n_s4_lo1 ? w_s4_sqa[33:0] : 34'd0;
            r_s4_sq2  <= n_s4_lo2 ? w_s4_sqb[33:0] : 34'd0;
            r_s4_tout <= w_s4_tout[18:0];
            r_s4_lo1  <= n_s4_lo1;
            r_s4_lo2  <= n_s4_lo2;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: OFF2, SENS2 and corrected OFF, SENS
    // ------------------------------------------------------------------
    logic [23:0]        r_s5_d1;
    logic signed [39:0] r_s5_off;
    logic signed [38:0] r_s5_sens;
    logic signed [18:0] r_s5_tout;

    logic [36:0] w_s5_sq5, w_s5_sq7;
    logic [37:0] w_s5_sq11;
    logic [37:0] w_s5_off2, w_s5_sens2;

    always_comb begin
        w_s5_sq5   = {r_s4_sq, 2'b0} + 37'(r_s4_sq);
        w_s5_sq7   = {r_s4_sq2, 3'b0} - 37'(r_s4_sq2);
        w_s5_sq11  = {1'b0, r_s4_sq2, 3'b0} + 38'({r_s4_sq2, 1'b0}) + 38'(r_s4_sq2);
        w_s5_off2  = 38'(w_s5_sq5[36:1]) + 38'(w_s5_sq7);
        w_s5_sens2 = 38'(w_s5_sq5[36:2]) + 38'(w_s5_sq11[37:1]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s5_d1   <= r_s4_d1;
            r_s5_off  <= 40'(r_s4_off) - $signed({2'b0, w_s5_off2});
            r_s5_sens <= 39'(r_s4_sens) - $signed({2'b0, w_s5_sens2[36:0]});
            r_s5_tout <= r_s4_tout;
        end
    end

    // ------------------------------------------------------------------
    // stages 6 and 7: D1 * SENS in the split multiplier
    // ------------------------------------------------------------------
    bsc_pkg::t_mul_en   w_mul_en;
    logic signed [63:0] w_prod;
    logic signed [39:0] r_s6_off, r_s7_off;
    logic signed [18:0] r_s6_tout, r_s7_tout;

    assign w_mul_en.st_a = w_en[6];
    assign w_mul_en.st_b = w_en[7];

    bsc_pmul u_pmul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_d1   (r_s5_d1),
        .i_sens (r_s5_sens),
        .o_prod (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_s6_off  <= r_s5_off;
            r_s6_tout <= r_s5_tout;
        end
        if (w_en[7]) begin
            r_s7_off  <= r_s6_off;
            r_s7_tout <= r_s6_tout;
        end
    end

    // ------------------------------------------------------------------
    // stage 8: D1 * SENS / 2^21 - OFF
    // ------------------------------------------------------------------
    logic signed [43:0] r_s8_x;
    logic signed [18:0] r_s8_tout;
    logic signed [63:0] w_s8_bp;

    assign w_s8_bp = w_prod + (w_prod[63] ? bsc_pkg::BIAS_P1 : 64'sd0);

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_s8_x    <= 44'($signed(w_s8_bp[63:21])) - 44'(r_s7_off);
            r_s8_tout <= r_s7_tout;
        end
    end

    // ------------------------------------------------------------------
    // stage 9: divide by 2^15, range flag, output register
    // ------------------------------------------------------------------
    logic signed [31:0] r_s9_p;
    logic signed [18:0] r_s9_tout;
    logic               r_s9_pv;

    logic signed [43:0] w_s9_bx;
    logic signed [31:0] w_s9_p;

    always_comb begin
        w_s9_bx = r_s8_x + (r_s8_x[43] ? bsc_pkg::BIAS_P2 : 44'sd0);
        w_s9_p  = 32'($signed(w_s9_bx[43:15]));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r_s9_p    <= w_s9_p;
            r_s9_tout <= r_s8_tout;
            r_s9_pv   <= (w_s9_p >= bsc_pkg::P_MIN) && (w_s9_p <= bsc_pkg::P_MAX);
        end
    end

    assign o_temperature_centi = r_s9_tout;
    assign o_pressure_pa       = r_s9_p;
    assign o_pressure_valid    = r_s9_pv;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // an input transfer always lands in stage 1
    `BSC_ASSERT_NXT(a_in_lands, i_clk, i_rst_n, i_in_valid && o_in_ready, r_vld[1])
    // a stage that cannot pass its item on still holds it next cycle
    `BSC_ASSERT_NXT(a_stall_keeps, i_clk, i_rst_n, |w_hold, (r_vld & $past(w_hold)) == $past(w_hold))
    // the below -15 C branch only runs inside the second-order branch
    `BSC_ASSERT_IMP(a_lo_nested, i_clk, i_rst_n, r_s4_lo2, r_s4_lo1)

endmodule
